// ===== hw/rtl/smrng_pkg.sv =====
// ----------------------------------------------------------------------------
// smrng_pkg
// Shared types and constants for the shuffled minimal-standard generator.
// ----------------------------------------------------------------------------
package smrng_pkg;

    localparam int VAL_W         = 31;
    localparam int MULT_W        = 15;
    localparam int PROD_W        = VAL_W + MULT_W;
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int WARMUP_STEPS  = TABLE_ENTRIES + 8;
    localparam int CNT_W         = $clog2(WARMUP_STEPS);
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [IDX_W-1:0]  t_index;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_data;

    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
    localparam t_value            LCG_MOD  = 31'h7fff_ffff;
    localparam t_value            OUT_MAX  = 31'd2147483389;

    // register index taken from paddr[2]
    localparam logic REG_SEED = 1'b0;

endpackage

// ===== hw/rtl/smrng_if.sv =====
// ----------------------------------------------------------------------------
// smrng_req_if / smrng_rsp_if
// Valid/ready channels for draw requests and random results.
// ----------------------------------------------------------------------------
interface smrng_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

interface smrng_rsp_if;
    logic                  valid;
    logic                  ready;
    smrng_pkg::t_value     random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ===== hw/rtl/shuffled_minimal_standard_rng_unit.sv =====
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng_unit
// Lehmer generator through a 32-entry Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// result path: after the request transaction the table is read, then the
//   write-back goes together with the output register load; a seeding draw
//   first runs the warm-up, one Lehmer step per cycle through the shared unit
// occupancy: a new request is accepted only in idle, after the write-back;
//   a full output register holds the write-back until the result is taken
// reset: control and seed register cleared (seed = 1); table contents are
//   undefined until the first request, which always seeds and fills it
module shuffled_minimal_standard_rng_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    smrng_req_if.sink           i_req,
    smrng_rsp_if.source         o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  smrng_pkg::t_addr    paddr,
    input  smrng_pkg::t_data    pwdata,
    output smrng_pkg::t_data    prdata,
    output logic                pready
);
    import smrng_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SEED  = 2'd1;
    localparam logic [1:0] ST_DRAW  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0] r_state, n_state;
    t_value     r_seed;
    t_value     r_lcg, n_lcg;
    t_value     r_last, n_last;
    t_count     r_cnt, n_cnt;
    t_value     r_rd_data;
    t_value     r_out, n_out;
    logic       r_out_valid, n_out_valid;

    t_value     table_mem [TABLE_ENTRIES];

    t_value     step_y;
    t_value     seed_init;
    t_index     draw_idx;
    logic       cfg_wr;
    logic       req_acc;
    logic       out_free;
    logic       mem_we;
    t_index     mem_waddr;
    t_value     mem_wdata;

    smrng_lehmer u_lehmer (
        .i_x (r_lcg),
        .o_y (step_y)
    );

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign prdata = (paddr[2] == REG_SEED) ? DATA_W'(r_seed) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= t_value'(1);
        end else if (cfg_wr) begin
            r_seed <= pwdata[VAL_W-1:0];
        end
    end

    // zero and the modulus itself both map to one
    assign seed_init = (r_seed == '0 || r_seed == LCG_MOD) ? t_value'(1) : r_seed;
    assign draw_idx  = r_last[VAL_W-1 -: IDX_W];

    assign i_req.ready        = (r_state == ST_IDLE);
    assign req_acc            = i_req.valid && i_req.ready;
    assign out_free           = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.random_value = r_out;

    always_comb begin
        n_state     = r_state;
        n_lcg       = r_lcg;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt[IDX_W-1:0];
        mem_wdata   = step_y;
        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.reseed || r_last == '0) begin
                        n_lcg   = seed_init;
                        n_cnt   = t_count'(WARMUP_STEPS - 1);
                        n_state = ST_SEED;
                    end else begin
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_SEED: begin
                n_lcg = step_y;
                // last entries of the warm-up fill the table top down
                if (r_cnt < t_count'(TABLE_ENTRIES)) begin
                    mem_we = 1'b1;
                end
                if (r_cnt == '0) begin
                    n_last  = step_y;
                    n_state = ST_DRAW;
                end else begin
                    n_cnt = r_cnt - t_count'(1);
                end
            end
            ST_DRAW: begin
                n_lcg   = step_y;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_waddr   = draw_idx;
                    mem_wdata   = r_lcg;
                    n_last      = r_rd_data;
                    n_out       = (r_rd_data > OUT_MAX) ? OUT_MAX : r_rd_data;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == ST_DRAW) begin
            r_rd_data <= table_mem[draw_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcg       <= t_value'(1);
            r_last      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcg       <= n_lcg;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== hw/rtl/smrng_lehmer.sv =====
// ----------------------------------------------------------------------------
// smrng_lehmer
// One Lehmer step: y = 16807 * x mod (2^31 - 1), Mersenne-style reduction.
// ----------------------------------------------------------------------------
module smrng_lehmer (
    input  smrng_pkg::t_value i_x,
    output smrng_pkg::t_value o_y
);
    import smrng_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [VAL_W:0]    fold;
    logic [VAL_W:0]    fold_sub;

    assign prod     = PROD_W'(i_x) * PROD_W'(LCG_MULT);
    // 2^31 == 1 mod M, so add high part onto low part
    assign fold     = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(prod[PROD_W-1:VAL_W]);
    assign fold_sub = fold - {1'b0, LCG_MOD};
    assign o_y      = (fold >= {1'b0, LCG_MOD}) ? fold_sub[VAL_W-1:0] : fold[VAL_W-1:0];

endmodule
